>>> hw/rtl/iirdf1_pkg.sv
// shared types and constants of the fourth-order direct form I iir filter
package iirdf1_pkg;

    // filter order and field widths
    localparam int HIST_ORDER = 4;
    localparam int CHAN_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int Y_W        = 40;
    localparam int FB_SHIFT   = 16;
    localparam int OPND_W     = Y_W - FB_SHIFT + 1;
    localparam int PROD_W     = COEF_W + OPND_W;
    localparam int ACC_W      = 64;
    localparam int FLAG_W     = 1;

    // one product per feedforward tap, two per feedback tap
    localparam int MAC_STEPS  = (HIST_ORDER + 1) + 2 * HIST_ORDER;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_B0_B1 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_B2_B3 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_B4    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_A1_A2 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_A3_A4 = CFG_IDX_W'(4);

    // saturation bounds of the stored output, in accumulator width
    localparam logic signed [ACC_W-1:0] Y_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] Y_MIN = 64'shFFFF_FF80_0000_0000;

    // one history row: x1..x4 and y1..y4 of a channel, index 0 is the newest
    typedef struct packed {
        logic [HIST_ORDER-1:0][Y_W-1:0]      y;
        logic [HIST_ORDER-1:0][SAMPLE_W-1:0] x;
    } t_hist_row;

    // control travelling with one product through the mac
    typedef struct packed {
        logic valid;
        logic shift;
        logic sub;
    } t_mac_ctrl;

endpackage

>>> hw/rtl/iirdf1_hist_mem.sv
// per-channel history memory with registered read and reset-cleared valid bits
module iirdf1_hist_mem #(
    parameter int DEPTH = 3,
    parameter int AW    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output iirdf1_pkg::t_hist_row o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  iirdf1_pkg::t_hist_row i_wr_data
);
    import iirdf1_pkg::*;

    t_hist_row        r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_hist_row        r_rd_data;
    logic             r_rd_valid;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a row never written reads as zero history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> hw/rtl/iirdf1_mac.sv
// shared multiplier with registered product and 64-bit accumulator
module iirdf1_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  iirdf1_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [iirdf1_pkg::OPND_W-1:0]   i_opnd,
    output logic signed [iirdf1_pkg::ACC_W-1:0]    o_acc
);
    import iirdf1_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctrl                r_ctrl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_scaled;
    logic signed [ACC_W-1:0]  w_term;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_opnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // low half of a feedback product is floored down to 28 fraction bits
    assign w_scaled = r_ctrl.shift ? (r_prod >>> FB_SHIFT) : r_prod;
    assign w_term   = {{(ACC_W-PROD_W){w_scaled[PROD_W-1]}}, w_scaled};

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_ctrl.valid) begin
            r_acc <= r_ctrl.sub ? (r_acc - w_term) : (r_acc + w_term);
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hw/rtl/iir_direct_form1_filter.sv
// top level of the multi-channel fourth-order direct form I iir filter
//
//  channel   | dir | tdata             | tuser
//  s_axis    | in  | sample_in [15:0]  | channel [1:0]
//  m_axis    | out | sample_out [15:0] | channel_out [1:0], clipped [2]
//  cfg write | in  | i_cfg_data [63:0] | i_cfg_index [2:0], i_cfg_we
//
// one word passes from accept through a history read, 13 products on the single shared
// 32x25 multiplier plus a drain step, rounding and write-back, then back to idle with
// ready high; no new word is accepted before then
// a word with channel number CHANNELS or more skips to write-back, leaving the history alone
// reset clears the history valid bits at once, so no clearing pass is needed
// a stalled output word holds the block in its write-back cycle until taken
module iir_direct_form1_filter #(
    parameter int CHANNELS = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [iirdf1_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // sample_in [15:0]
    input  logic [iirdf1_pkg::CHAN_W-1:0]         s_axis_tuser,  // channel [1:0]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [iirdf1_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // sample_out [15:0]
    output logic [iirdf1_pkg::CHAN_W:0]           m_axis_tuser,  // channel_out [1:0], clipped [2]
    input  logic                                  i_cfg_we,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iirdf1_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import iirdf1_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_W = $clog2(MAC_STEPS + 1);

    localparam logic signed [Y_W:0] S_MAX = (Y_W+1)'(32767);
    localparam logic signed [Y_W:0] S_MIN = (Y_W+1)'(-32768);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [STEP_W-1:0]         r_step;
    logic [CHAN_W-1:0]         r_chan;
    logic signed [SAMPLE_W-1:0] r_x0;
    logic                      r_bad;
    logic signed [Y_W-1:0]     r_y;
    logic                      r_y_clip;

    logic [CFG_DATA_W-1:0]     r_coef_b01, r_coef_b23, r_coef_a12, r_coef_a34;
    logic [COEF_W-1:0]         r_coef_b4;

    logic                      r_out_valid;
    logic [CHAN_W-1:0]         r_out_chan;
    logic [SAMPLE_W-1:0]       r_out_sample;
    logic                      r_out_clip;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_done;
    logic [3:0]                w_ch_ext;
    logic [AW-1:0]             w_addr;
    t_hist_row                 w_row;
    t_hist_row                 w_new_row;

    logic signed [COEF_W-1:0]  w_b [HIST_ORDER+1];
    logic signed [COEF_W-1:0]  w_a [HIST_ORDER];
    logic signed [COEF_W-1:0]  w_coef;
    logic signed [OPND_W-1:0]  w_opnd;
    t_mac_ctrl                 w_ctrl;
    logic [STEP_W-1:0]         w_xm1;
    logic [STEP_W-1:0]         w_fb;
    logic [1:0]                w_fb_idx;
    logic [Y_W-1:0]            w_ysel;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_rnd;
    logic signed [ACC_W-1:0]   w_shr;
    logic signed [Y_W:0]       w_ysum;
    logic signed [Y_W:0]       w_s;
    logic [SAMPLE_W-1:0]       w_s_sat;
    logic                      w_s_clip;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_done        = (r_state == ST_DONE) && w_out_free;

    // channel to row address
    assign w_ch_ext = {{(4-CHAN_W){1'b0}}, r_chan};
    assign w_addr   = w_ch_ext[AW-1:0];

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b01 <= '0;
            r_coef_b23 <= '0;
            r_coef_b4  <= '0;
            r_coef_a12 <= '0;
            r_coef_a34 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_B0_B1: r_coef_b01 <= i_cfg_data;
                REG_B2_B3: r_coef_b23 <= i_cfg_data;
                REG_B4:    r_coef_b4  <= i_cfg_data[COEF_W-1:0];
                REG_A1_A2: r_coef_a12 <= i_cfg_data;
                REG_A3_A4: r_coef_a34 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack coefficients
    assign w_b[0] = r_coef_b01[COEF_W-1:0];
    assign w_b[1] = r_coef_b01[2*COEF_W-1:COEF_W];
    assign w_b[2] = r_coef_b23[COEF_W-1:0];
    assign w_b[3] = r_coef_b23[2*COEF_W-1:COEF_W];
    assign w_b[4] = r_coef_b4;
    assign w_a[0] = r_coef_a12[COEF_W-1:0];
    assign w_a[1] = r_coef_a12[2*COEF_W-1:COEF_W];
    assign w_a[2] = r_coef_a34[COEF_W-1:0];
    assign w_a[3] = r_coef_a34[2*COEF_W-1:COEF_W];

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (32'(s_axis_tuser) >= 32'(CHANNELS)) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  n_state = ST_MAC;
            ST_MAC: begin
                if (r_step == STEP_W'(MAC_STEPS)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MAC) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chan <= s_axis_tuser;
            r_x0   <= s_axis_tdata;
            r_bad  <= (32'(s_axis_tuser) >= 32'(CHANNELS));
        end
    end

    iirdf1_hist_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (w_addr),
        .o_rd_data (w_row),
        .i_wr_en   (w_done && !r_bad),
        .i_wr_addr (w_addr),
        .i_wr_data (w_new_row)
    );

    // operand selection: b0*x0, b1..b4 * x1..x4, then high and low halves of each a*y
    assign w_xm1    = r_step - STEP_W'(1);
    assign w_fb     = r_step - STEP_W'(HIST_ORDER + 1);
    assign w_fb_idx = w_fb[2:1];
    assign w_ysel   = w_row.y[w_fb_idx];

    always_comb begin
        w_coef       = '0;
        w_opnd       = '0;
        w_ctrl       = '0;
        w_ctrl.valid = (r_state == ST_MAC) && (r_step < STEP_W'(MAC_STEPS));
        if (r_step == '0) begin
            w_coef = w_b[0];
            w_opnd = {{(OPND_W-SAMPLE_W){r_x0[SAMPLE_W-1]}}, r_x0};
        end else if (r_step <= STEP_W'(HIST_ORDER)) begin
            w_coef = w_b[r_step[2:0]];
            w_opnd = {{(OPND_W-SAMPLE_W){w_row.x[w_xm1[1:0]][SAMPLE_W-1]}},
                      w_row.x[w_xm1[1:0]]};
        end else begin
            w_coef     = w_a[w_fb_idx];
            w_ctrl.sub = 1'b1;
            if (w_fb[0]) begin
                w_ctrl.shift = 1'b1;
                w_opnd       = {{(OPND_W-FB_SHIFT){1'b0}}, w_ysel[FB_SHIFT-1:0]};
            end else begin
                w_opnd = {w_ysel[Y_W-1], w_ysel[Y_W-1:FB_SHIFT]};
            end
        end
    end

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_accept),
        .i_ctrl  (w_ctrl),
        .i_coef  (w_coef),
        .i_opnd  (w_opnd),
        .o_acc   (w_acc)
    );

    // round to 16 fraction bits and saturate to the stored width
    assign w_rnd = w_acc + ACC_W'(2048);
    assign w_shr = w_rnd >>> 12;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            if (w_shr > Y_MAX) begin
                r_y      <= Y_MAX[Y_W-1:0];
                r_y_clip <= 1'b1;
            end else if (w_shr < Y_MIN) begin
                r_y      <= Y_MIN[Y_W-1:0];
                r_y_clip <= 1'b1;
            end else begin
                r_y      <= w_shr[Y_W-1:0];
                r_y_clip <= 1'b0;
            end
        end
    end

    // round and saturate the returned sample
    assign w_ysum = {r_y[Y_W-1], r_y} + (Y_W+1)'(32768);
    assign w_s    = w_ysum >>> FB_SHIFT;

    always_comb begin
        w_s_sat  = w_s[SAMPLE_W-1:0];
        w_s_clip = 1'b0;
        if (w_s > S_MAX) begin
            w_s_sat  = S_MAX[SAMPLE_W-1:0];
            w_s_clip = 1'b1;
        end else if (w_s < S_MIN) begin
            w_s_sat  = S_MIN[SAMPLE_W-1:0];
            w_s_clip = 1'b1;
        end
    end

    // shifted history written back
    assign w_new_row.x = {w_row.x[HIST_ORDER-2:0], r_x0};
    assign w_new_row.y = {w_row.y[HIST_ORDER-2:0], r_y};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_chan   <= r_chan;
            r_out_sample <= r_bad ? '0 : w_s_sat;
            r_out_clip   <= r_bad ? 1'b0 : (r_y_clip || w_s_clip);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = {r_out_clip, r_out_chan};

endmodule

>>> hw/rtl/iirdf1_checker.sv
// port-level checks of the iir filter and their bind to the top level
module iirdf1_checker #(
    parameter int CHANNELS = 3
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [iirdf1_pkg::SAMPLE_W-1:0]   m_axis_tdata,
    input logic [iirdf1_pkg::CHAN_W:0]       m_axis_tuser
);
    import iirdf1_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // a new output word is loaded only while the input side is busy
    a_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output word appeared without a finished computation");

    // unknown channel gives a zero, unclipped sample
    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (32'(m_axis_tuser[CHAN_W-1:0]) >= 32'(CHANNELS)) |->
            (m_axis_tdata == '0) && !m_axis_tuser[CHAN_W])
        else $error("out-of-range channel returned nonzero data");

endmodule

bind iir_direct_form1_filter iirdf1_checker #(.CHANNELS(CHANNELS)) u_checker (.*);
